@@ hw/rtl/pmt_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet tracker.
package pmt_pkg;

  // Packet ring; holds at most QUEUE_DEPTH-1 packets
  localparam int QUEUE_DEPTH = 32;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Op queue between front and back
  localparam int OPQ_DEPTH  = 4;
  localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);

  // Result queue on the output side
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  // Input commands
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  // Config register indexes
  localparam logic [1:0] CFG_CLAMP  = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Op kinds handed from front to back
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [2:0]         buttons;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } pkt_t;

  typedef struct packed {
    logic kind;
    pkt_t pkt;
  } op_t;

  typedef struct packed {
    logic        clamp_enable;
    logic [14:0] screen_width;
    logic [14:0] screen_height;
  } cfg_t;

endpackage

@@ hw/rtl/pmt_front.sv @@
// Front end: byte parser, cursor update and op classification.
module pmt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  pmt_pkg::cfg_t      cfg,
  input  logic               take,
  input  logic [1:0]         command,
  input  logic [7:0]         data_byte,
  input  logic               from_aux,
  input  logic signed [15:0] set_x,
  input  logic signed [15:0] set_y,
  output logic               op_enq,
  output pmt_pkg::op_t       op
);
  import pmt_pkg::*;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_DX    = 2'd1;
  localparam logic [1:0] PH_DY    = 2'd2;

  logic [1:0]         phase_r, phase_nxt;
  logic [2:0]         buttons_r, buttons_nxt;
  logic [7:0]         delta_x_r, delta_x_nxt;
  logic signed [15:0] cursor_x_r, cursor_x_nxt;
  logic signed [15:0] cursor_y_r, cursor_y_nxt;
  logic signed [16:0] sum_x, sum_y;
  logic signed [15:0] new_x, new_y;
  logic               byte_ok;

  // Floor at 0, ceiling at size-1 (size 0 acts as 1) or 32767 unclamped
  function automatic logic signed [15:0] limit(input logic signed [16:0] v,
                                               input logic [14:0] size,
                                               input logic en);
    logic [14:0]        top;
    logic signed [16:0] r;
    if (!en) begin
      top = 15'h7FFF;
    end else if (size == 15'd0) begin
      top = 15'd0;
    end else begin
      top = size - 15'd1;
    end
    r = v;
    if (v < 17'sd0) begin
      r = 17'sd0;
    end else if (v > $signed({2'b00, top})) begin
      r = $signed({2'b00, top});
    end
    return r[15:0];
  endfunction

  assign sum_x = {cursor_x_r[15], cursor_x_r} + {{9{delta_x_r[7]}}, delta_x_r};
  assign sum_y = {cursor_y_r[15], cursor_y_r} - {{9{data_byte[7]}}, data_byte};
  assign new_x = limit(sum_x, cfg.screen_width, cfg.clamp_enable);
  assign new_y = limit(sum_y, cfg.screen_height, cfg.clamp_enable);

  assign byte_ok = take && (command == CMD_BYTE) && from_aux;

  always_comb begin
    phase_nxt    = phase_r;
    buttons_nxt  = buttons_r;
    delta_x_nxt  = delta_x_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    if (byte_ok) begin
      unique case (phase_r)
        PH_FIRST: begin
          buttons_nxt = data_byte[2:0];
          phase_nxt   = data_byte[3] ? PH_DX : PH_FIRST;
        end
        PH_DX: begin
          delta_x_nxt = data_byte;
          phase_nxt   = PH_DY;
        end
        PH_DY: begin
          cursor_x_nxt = new_x;
          cursor_y_nxt = new_y;
          phase_nxt    = PH_FIRST;
        end
        default: phase_nxt = PH_FIRST;
      endcase
    end else if (take && (command == CMD_SET)) begin
      cursor_x_nxt = set_x;
      cursor_y_nxt = set_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      buttons_r  <= '0;
      delta_x_r  <= '0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      buttons_r  <= buttons_nxt;
      delta_x_r  <= delta_x_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
    end
  end

  // Completed packets and read requests go on to the back end, in order
  assign op_enq = (byte_ok && (phase_r == PH_DY)) || (take && (command == CMD_READ));
  assign op.kind        = (command == CMD_READ) ? OP_READ : OP_PUSH;
  assign op.pkt.buttons = buttons_r;
  assign op.pkt.pos_x   = new_x;
  assign op.pkt.pos_y   = new_y;

endmodule

@@ hw/rtl/pmt_opq.sv @@
// Short op queue decoupling the front end from the back end.
module pmt_opq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         enq,
  input  pmt_pkg::op_t din,
  output logic         full,
  input  logic         deq,
  output pmt_pkg::op_t dout,
  output logic         empty
);
  import pmt_pkg::*;

  op_t                  slot_r [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_r, rd_r;
  logic [OPQ_CNT_W-1:0] cnt_r;
  logic                 do_enq, do_deq;

  assign full   = (cnt_r == OPQ_CNT_W'(OPQ_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_enq = enq && !full;
  assign do_deq = deq && !empty;
  assign dout   = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slot_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_enq) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_deq) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_enq && !do_deq) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_deq && !do_enq) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/pmt_back.sv @@
// Back end: packet ring memory, read stage and result queue.
module pmt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  pmt_pkg::op_t       op,
  output logic               op_deq,
  output logic               empty,
  input  logic               pop,
  output logic               out_packet_valid,
  output logic [2:0]         out_buttons,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y
);
  import pmt_pkg::*;

  typedef struct packed {
    logic packet_valid;
    pkt_t pkt;
  } res_t;

  pkt_t                 ring [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    head_r, tail_r, head_inc, tail_inc;
  logic                 ring_empty, do_push, do_read, credit_ok;

  pkt_t                 rd_data_r;
  logic                 rd_valid_r, rd_hit_r;

  res_t                 res_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] res_wr_r, res_rd_r;
  logic [RES_CNT_W-1:0] res_cnt_r;
  logic                 res_pop;
  res_t                 res_in;

  assign head_inc   = (head_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign ring_empty = (head_r == tail_r);

  // A read may only issue if its result is sure of a slot
  assign credit_ok = (res_cnt_r + RES_CNT_W'(rd_valid_r)) < RES_CNT_W'(RES_DEPTH);
  assign do_push   = op_valid && (op.kind == OP_PUSH);
  assign do_read   = op_valid && (op.kind == OP_READ) && credit_ok;
  assign op_deq    = do_push || do_read;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ring[head_r] <= op.pkt;
    end
    if (do_read) begin
      rd_data_r <= ring[tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      rd_valid_r <= 1'b0;
      rd_hit_r   <= 1'b0;
    end else begin
      rd_valid_r <= do_read;
      rd_hit_r   <= do_read && !ring_empty;
      if (do_push) begin
        head_r <= head_inc;
        // full ring: oldest packet is overwritten
        if (head_inc == tail_r) begin
          tail_r <= tail_inc;
        end
      end else if (do_read && !ring_empty) begin
        tail_r <= tail_inc;
      end
    end
  end

  // Result queue
  assign res_in.packet_valid = rd_hit_r;
  assign res_in.pkt          = rd_hit_r ? rd_data_r : '0;
  assign empty               = (res_cnt_r == '0);
  assign res_pop             = pop && !empty;

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      res_r[res_wr_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (rd_valid_r) begin
        res_wr_r <= res_wr_r + 1'b1;
      end
      if (res_pop) begin
        res_rd_r <= res_rd_r + 1'b1;
      end
      if (rd_valid_r && !res_pop) begin
        res_cnt_r <= res_cnt_r + 1'b1;
      end else if (res_pop && !rd_valid_r) begin
        res_cnt_r <= res_cnt_r - 1'b1;
      end
    end
  end

  assign out_packet_valid = res_r[res_rd_r].packet_valid;
  assign out_buttons      = res_r[res_rd_r].pkt.buttons;
  assign out_pos_x        = res_r[res_rd_r].pkt.pos_x;
  assign out_pos_y        = res_r[res_rd_r].pkt.pos_y;

  // A beat leaving the read stage always finds a free slot
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> (res_cnt_r < RES_CNT_W'(RES_DEPTH)))
    else $error("result queue overrun");

  // Ring is never empty straight after a push
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> (head_r != tail_r))
    else $error("ring empty after push");

  // A read of an empty ring leaves the tail alone
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (do_read && ring_empty) |=> $stable(tail_r))
    else $error("tail moved on empty read");

  // Hit results only come from a non-empty ring
  a_hit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (do_read && ring_empty) |=> (rd_valid_r && !rd_hit_r))
    else $error("hit reported on empty ring");

endmodule

@@ hw/rtl/ps2_mouse_packet_tracker.sv @@
// PS/2 mouse packet tracker: top level with config registers.
// Throughput: one beat per clock; a read waits in the op queue while the 4-deep result queue
//   has no slot free (the beat in the read stage counts); input stalls once the op queue fills.
// Path: a read result passes the op queue, the ring read stage and the result queue before it
//   can be popped; a packet passes the op queue on its way to the ring, bytes and sets act at once.
// Reset (sync, active low): parser at first byte, cursor 0,0, queues empty, clamp on 640x480.
module ps2_mouse_packet_tracker (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_data_byte,
  input  logic               in_from_aux,
  input  logic signed [15:0] in_set_x,
  input  logic signed [15:0] in_set_y,
  // result channel
  output logic               empty,
  input  logic               pop,
  output logic               out_packet_valid,
  output logic [2:0]         out_buttons,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import pmt_pkg::*;

  cfg_t cfg_r;
  logic take;
  logic op_enq, op_full, op_empty, op_deq;
  op_t  op_in, op_out;

  // Config registers; writes are always taken, unknown indexes ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clamp_enable  <= 1'b1;
      cfg_r.screen_width  <= 15'd640;
      cfg_r.screen_height <= 15'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CLAMP:  cfg_r.clamp_enable  <= cfg_data[0];
        CFG_WIDTH:  cfg_r.screen_width  <= cfg_data;
        CFG_HEIGHT: cfg_r.screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end stalls only on a full op queue
  assign full = op_full;
  assign take = push && !op_full;

  pmt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .take      (take),
    .command   (in_command),
    .data_byte (in_data_byte),
    .from_aux  (in_from_aux),
    .set_x     (in_set_x),
    .set_y     (in_set_y),
    .op_enq    (op_enq),
    .op        (op_in)
  );

  pmt_opq u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .enq   (op_enq),
    .din   (op_in),
    .full  (op_full),
    .deq   (op_deq),
    .dout  (op_out),
    .empty (op_empty)
  );

  pmt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (!op_empty),
    .op               (op_out),
    .op_deq           (op_deq),
    .empty            (empty),
    .pop              (pop),
    .out_packet_valid (out_packet_valid),
    .out_buttons      (out_buttons),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y)
  );

endmodule
